/* hdl/afw_pkg.sv */
package afw_pkg;

   // default sizes of the frame store and of the largest source side
   localparam int FRAME_PIXELS_DEF = 65536;
   localparam int MAX_SIDE_DEF     = 1024;

   // field widths
   localparam int FUNC_W     = 1;
   localparam int PA_W       = 16;
   localparam int RGB_W      = 8;
   localparam int DEST_W     = 10;
   localparam int GRAY_W     = 8;
   localparam int CPAR_W     = 24;
   localparam int OFF_W      = 30;
   localparam int SIDE_FLD_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   // fixed-point datapath widths
   localparam int FRAC_W = 16;
   localparam int PROD_W = CPAR_W + DEST_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int INT_W  = SUM_W - FRAC_W;

   localparam int HALF_Q16 = 32768;

   // divide by three: (sum * 683) >> 11 is exact for sums up to 765
   localparam int             SUM3_W     = RGB_W + 2;
   localparam int             DIV3_PW    = 2 * SUM3_W;
   localparam logic [SUM3_W-1:0] DIV3_MUL = 10'd683;
   localparam int             DIV3_SHIFT = 11;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_WARP = 1'b1;

   // register reset values
   localparam logic [CPAR_W-1:0]     COEF_ONE   = 24'd65536;
   localparam logic [SIDE_FLD_W-1:0] SIDE_RESET = 11'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COL_PER_X     = 3'd0,
      CSR_COL_PER_Y     = 3'd1,
      CSR_ROW_PER_X     = 3'd2,
      CSR_ROW_PER_Y     = 3'd3,
      CSR_COL_OFFSET    = 3'd4,
      CSR_ROW_OFFSET    = 3'd5,
      CSR_SOURCE_WIDTH  = 3'd6,
      CSR_SOURCE_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PA_W-1:0]   pixel_address;
      logic [RGB_W-1:0]  red;
      logic [RGB_W-1:0]  green;
      logic [RGB_W-1:0]  blue;
      logic [DEST_W-1:0] dest_x;
      logic [DEST_W-1:0] dest_y;
   } req_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic              inside_res;
   } rsp_type;

endpackage

/* hdl/affine_warp_nearest_gray.sv */
// nearest-neighbour affine warp with gray output
//
// req channel (req_valid / req_stall / req_data): one item per cycle. a load item
// (func FUNC_LOAD) writes (r+g+b)/3 into the frame store at pixel_address; loads at
// or beyond FRAME_PIXELS are dropped. a warp item (func FUNC_WARP) maps
// (dest_x, dest_y) through the 2x2 matrix and offset, rounds half up and truncates
// toward zero, and gives one rsp item: the stored gray value and inside_res set, or
// gray 0 with inside_res clear when the point falls outside the source image
// rsp channel (rsp_valid / rsp_stall / rsp_data): loads give no rsp item
// csr channel (csr_valid / csr_ready / csr_index / csr_data): always ready, write
// only while no item is in flight
// stages: products, sums, truncation, bounds, address, R wrap stages, where R is
// clog2 of (MAX_SIDE^2 - 1) / FRAME_PIXELS + 1, at least 1 (R = 4 with default
// parameters), read, output. throughput: one item per cycle while req_stall is low,
// set by the single store port that serves loads and reads in item order
// reset: clears all valid bits and returns the registers to an identity map over a
// 256 x 256 image; the frame store keeps its contents and needs no clearing pass
// stall: rsp_stall holds the rsp item; the pipeline keeps filling its bubbles and
// req_stall rises only once every stage holds an item
module affine_warp_nearest_gray
   import afw_pkg::*;
#(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
   parameter int MAX_SIDE     = MAX_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W  = $clog2(FRAME_PIXELS);
   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int LIN_W   = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int RW      = ((LIN_W > ADDR_W) ? LIN_W : ADDR_W) + 1;
   localparam int MP_W    = COORD_W + SIDE_W;
   // largest quotient of row*width+col by the store size sets the wrap stages
   localparam int Q_MAX   = (MAX_SIDE * MAX_SIDE - 1) / FRAME_PIXELS;
   localparam int RED_N   = (Q_MAX == 0) ? 1 : $clog2(Q_MAX + 1);

   typedef struct packed {
      logic              warp;
      logic              we;
      logic              in_src;
      logic [GRAY_W-1:0] ld_gray;
   } tag_type;

   // ---------------- configuration registers ----------------
   logic signed [CPAR_W-1:0] col_per_x_ff, col_per_y_ff, row_per_x_ff, row_per_y_ff;
   logic signed [OFF_W-1:0]  col_offset_ff, row_offset_ff;
   logic [SIDE_FLD_W-1:0]    source_width_ff, source_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_per_x_ff     <= COEF_ONE;
         col_per_y_ff     <= '0;
         row_per_x_ff     <= '0;
         row_per_y_ff     <= COEF_ONE;
         col_offset_ff    <= '0;
         row_offset_ff    <= '0;
         source_width_ff  <= SIDE_RESET;
         source_height_ff <= SIDE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COL_PER_X:     col_per_x_ff     <= csr_data[CPAR_W-1:0];
            CSR_COL_PER_Y:     col_per_y_ff     <= csr_data[CPAR_W-1:0];
            CSR_ROW_PER_X:     row_per_x_ff     <= csr_data[CPAR_W-1:0];
            CSR_ROW_PER_Y:     row_per_y_ff     <= csr_data[CPAR_W-1:0];
            CSR_COL_OFFSET:    col_offset_ff    <= csr_data[OFF_W-1:0];
            CSR_ROW_OFFSET:    row_offset_ff    <= csr_data[OFF_W-1:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data[SIDE_FLD_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_data[SIDE_FLD_W-1:0];
            default: ;
         endcase
      end
   end

   // image sides saturate at MAX_SIDE
   logic [SIDE_W-1:0] side_w, side_h;

   always_comb begin
      if (int'(source_width_ff) > MAX_SIDE) begin
         side_w = SIDE_W'(MAX_SIDE);
      end else begin
         side_w = SIDE_W'(source_width_ff);
      end
      if (int'(source_height_ff) > MAX_SIDE) begin
         side_h = SIDE_W'(MAX_SIDE);
      end else begin
         side_h = SIDE_W'(source_height_ff);
      end
   end

   // ---------------- pipeline registers ----------------
   logic                     s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, rd_v_ff;
   tag_type                  s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff;
   logic [PA_W-1:0]          s1_pa_ff, s2_pa_ff, s3_pa_ff, s4_pa_ff;
   logic signed [PROD_W-1:0] s1_pcx_ff, s1_pcy_ff, s1_prx_ff, s1_pry_ff;
   logic signed [SUM_W-1:0]  s2_col_ff, s2_row_ff;
   logic signed [INT_W-1:0]  s3_col_ff, s3_row_ff;
   logic [COORD_W-1:0]       s4_col_ff, s4_row_ff;
   logic [RW-1:0]            s5_lin_ff;
   logic                     rd_inside_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic    red_v_ff   [RED_N];
   tag_type red_tag_ff [RED_N];
   logic [RW-1:0] red_lin_ff [RED_N];

   // ---------------- advance chain ----------------
   // a stage loads when it is empty or the stage after it loads too,
   // so bubbles are squeezed out while the output is stalled
   logic ld_out, ld_rd, ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
   logic red_ld [RED_N];

   assign ld_out = !rsp_valid_ff || !rsp_stall;
   assign ld_rd  = !rd_v_ff || ld_out;
   assign ld_s5  = !s5_v_ff || red_ld[0];
   assign ld_s4  = !s4_v_ff || ld_s5;
   assign ld_s3  = !s3_v_ff || ld_s4;
   assign ld_s2  = !s2_v_ff || ld_s3;
   assign ld_s1  = !s1_v_ff || ld_s2;

   assign req_stall = !ld_s1;

   // ---------------- stage 1: products, gray of a load ----------------
   logic signed [DEST_W:0]    x_s, y_s;
   logic signed [PROD_W-1:0]  s1_pcx_in, s1_pcy_in, s1_prx_in, s1_pry_in;
   logic [SUM3_W-1:0]         rgb_sum;
   logic [DIV3_PW-1:0]        div3_prod;
   tag_type                   s1_tag_in;

   always_comb begin
      x_s       = $signed({1'b0, req_data.dest_x});
      y_s       = $signed({1'b0, req_data.dest_y});
      s1_pcx_in = col_per_x_ff * x_s;
      s1_pcy_in = col_per_y_ff * y_s;
      s1_prx_in = row_per_x_ff * x_s;
      s1_pry_in = row_per_y_ff * y_s;
      rgb_sum   = SUM3_W'(req_data.red) + SUM3_W'(req_data.green)
                + SUM3_W'(req_data.blue);
      div3_prod = DIV3_PW'(rgb_sum) * DIV3_PW'(DIV3_MUL);
      s1_tag_in.warp    = (req_data.func == FUNC_WARP);
      s1_tag_in.we      = (req_data.func == FUNC_LOAD)
                        && (int'(req_data.pixel_address) < FRAME_PIXELS);
      s1_tag_in.in_src  = 1'b0;
      s1_tag_in.ld_gray = div3_prod[DIV3_SHIFT +: GRAY_W];
   end

   // ---------------- stage 2: Q.16 sums plus one half ----------------
   logic signed [SUM_W-1:0] s2_col_in, s2_row_in;

   always_comb begin
      s2_col_in = SUM_W'(s1_pcx_ff) + SUM_W'(s1_pcy_ff) + SUM_W'(col_offset_ff)
                + SUM_W'(HALF_Q16);
      s2_row_in = SUM_W'(s1_prx_ff) + SUM_W'(s1_pry_ff) + SUM_W'(row_offset_ff)
                + SUM_W'(HALF_Q16);
   end

   // ---------------- stage 3: truncate toward zero ----------------
   // floor, plus one for a negative value with a fraction
   logic signed [INT_W-1:0] s3_col_in, s3_row_in;
   logic                    col_up, row_up;

   always_comb begin
      col_up    = s2_col_ff[SUM_W-1] && (s2_col_ff[FRAC_W-1:0] != '0);
      row_up    = s2_row_ff[SUM_W-1] && (s2_row_ff[FRAC_W-1:0] != '0);
      s3_col_in = $signed(s2_col_ff[SUM_W-1:FRAC_W]) + $signed({{(INT_W-1){1'b0}}, col_up});
      s3_row_in = $signed(s2_row_ff[SUM_W-1:FRAC_W]) + $signed({{(INT_W-1){1'b0}}, row_up});
   end

   // ---------------- stage 4: bounds check ----------------
   tag_type s4_tag_in;

   always_comb begin
      s4_tag_in        = s3_tag_ff;
      s4_tag_in.in_src = !s3_col_ff[INT_W-1] && !s3_row_ff[INT_W-1]
                       && (s3_col_ff[INT_W-2:0] < (INT_W-1)'(side_w))
                       && (s3_row_ff[INT_W-2:0] < (INT_W-1)'(side_h));
   end

   // ---------------- stage 5: linear address ----------------
   // a load carries its own address down the same path
   logic [MP_W-1:0] lin_prod;
   logic [RW-1:0]   s5_lin_in;

   always_comb begin
      lin_prod = MP_W'(s4_row_ff) * MP_W'(side_w);
      if (s4_tag_ff.warp) begin
         s5_lin_in = RW'(lin_prod) + RW'(s4_col_ff);
      end else begin
         s5_lin_in = RW'(s4_pa_ff);
      end
   end

   // ---------------- control registers of stages 1 to 5 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (ld_s1) begin
            s1_v_ff <= req_valid;
         end
         if (ld_s2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (ld_s3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (ld_s4) begin
            s4_v_ff <= s3_v_ff;
         end
         if (ld_s5) begin
            s5_v_ff <= s4_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_s1) begin
         s1_tag_ff <= s1_tag_in;
         s1_pa_ff  <= req_data.pixel_address;
         s1_pcx_ff <= s1_pcx_in;
         s1_pcy_ff <= s1_pcy_in;
         s1_prx_ff <= s1_prx_in;
         s1_pry_ff <= s1_pry_in;
      end
      if (ld_s2) begin
         s2_tag_ff <= s1_tag_ff;
         s2_pa_ff  <= s1_pa_ff;
         s2_col_ff <= s2_col_in;
         s2_row_ff <= s2_row_in;
      end
      if (ld_s3) begin
         s3_tag_ff <= s2_tag_ff;
         s3_pa_ff  <= s2_pa_ff;
         s3_col_ff <= s3_col_in;
         s3_row_ff <= s3_row_in;
      end
      if (ld_s4) begin
         s4_tag_ff <= s4_tag_in;
         s4_pa_ff  <= s3_pa_ff;
         s4_col_ff <= s3_col_ff[COORD_W-1:0];
         s4_row_ff <= s3_row_ff[COORD_W-1:0];
      end
      if (ld_s5) begin
         s5_tag_ff <= s4_tag_ff;
         s5_lin_ff <= s5_lin_in;
      end
   end

   // ---------------- wrap stages: address modulo FRAME_PIXELS ----------------
   // restoring reduction, one quotient bit per stage, largest multiple first
   for (genvar j = 0; j < RED_N; j++) begin : g_red
      localparam logic [RW-1:0] SUB_C = RW'(FRAME_PIXELS) << (RED_N - 1 - j);

      logic          src_v;
      tag_type       src_tag;
      logic [RW-1:0] src_lin;
      logic [RW-1:0] red_lin_in;

      if (j == 0) begin : g_first
         assign src_v   = s5_v_ff;
         assign src_tag = s5_tag_ff;
         assign src_lin = s5_lin_ff;
      end else begin : g_next
         assign src_v   = red_v_ff[j-1];
         assign src_tag = red_tag_ff[j-1];
         assign src_lin = red_lin_ff[j-1];
      end

      if (j == RED_N - 1) begin : g_last_ld
         assign red_ld[j] = !red_v_ff[j] || ld_rd;
      end else begin : g_mid_ld
         assign red_ld[j] = !red_v_ff[j] || red_ld[j+1];
      end

      assign red_lin_in = (src_lin >= SUB_C) ? (src_lin - SUB_C) : src_lin;

      always_ff @(posedge clock) begin
         if (reset) begin
            red_v_ff[j] <= 1'b0;
         end else if (red_ld[j]) begin
            red_v_ff[j] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (red_ld[j]) begin
            red_tag_ff[j] <= src_tag;
            red_lin_ff[j] <= red_lin_in;
         end
      end
   end

   // ---------------- frame store ----------------
   // loads and reads reach the single port in item order, so a read always
   // sees every earlier load and never a later one
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [GRAY_W-1:0] ram_rdata;

   assign ram_addr = red_lin_ff[RED_N-1][ADDR_W-1:0];
   assign ram_we   = red_v_ff[RED_N-1] && red_tag_ff[RED_N-1].we && ld_rd;
   assign ram_re   = red_v_ff[RED_N-1] && red_tag_ff[RED_N-1].warp && ld_rd;

   afw_ram #(
      .WIDTH (GRAY_W),
      .DEPTH (FRAME_PIXELS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (red_tag_ff[RED_N-1].ld_gray),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // ---------------- read stage and output register ----------------
   // loads end at the store; only warps go on to the rsp register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld_rd) begin
            rd_v_ff <= red_v_ff[RED_N-1] && red_tag_ff[RED_N-1].warp;
         end
         if (ld_out) begin
            rsp_valid_ff <= rd_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_rd) begin
         rd_inside_ff <= red_tag_ff[RED_N-1].in_src;
      end
      if (ld_out) begin
         // outside points give gray 0
         rsp_data_ff.gray       <= rd_inside_ff ? ram_rdata : '0;
         rsp_data_ff.inside_res <= rd_inside_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/afw_ram.sv */
module afw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/afw_checker.sv */
module afw_checker
   import afw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled rsp item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // no rsp item straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // input only backs up when the output is blocked
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req stalled with output free");

   // an outside point always reads as gray 0
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.inside_res |-> rsp_data.gray == '0)
      else $error("outside point with non-zero gray");

endmodule

bind affine_warp_nearest_gray afw_checker u_afw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/sv/affine_warp_nearest_gray_checker.sv */
`timescale 1ns / 100ps
module affine_warp_nearest_gray_checker
   import afw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    waiting
);

   localparam int FRAME_PIXELS = FRAME_PIXELS_DEF;
   localparam int MAX_SIDE     = MAX_SIDE_DEF;

   logic [CPAR_W-1:0]     col_per_x, col_per_y, row_per_x, row_per_y;
   logic [OFF_W-1:0]      col_offset, row_offset;
   logic [SIDE_FLD_W-1:0] source_width, source_height;
   logic [GRAY_W-1:0]     gray_store [FRAME_PIXELS];
   rsp_type               pending_pixels [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      failures++;
   endtask

   // signed q.16 sum plus one half, truncated toward zero
   function automatic longint source_axis(input logic [CPAR_W-1:0] per_x,
                                          input logic [CPAR_W-1:0] per_y,
                                          input logic [OFF_W-1:0]  offset,
                                          input logic [DEST_W-1:0] x,
                                          input logic [DEST_W-1:0] y);
      longint acc;
      acc = longint'($signed(per_x)) * longint'(x) + longint'($signed(per_y)) * longint'(y)
            + longint'($signed(offset)) + HALF_Q16;
      return (acc >= 0) ? (acc >>> FRAC_W) : -((-acc) >>> FRAC_W);
   endfunction

   function automatic rsp_type predict_pixel(input req_type item);
      longint  col, row, w, h;
      rsp_type px;
      w   = (source_width > MAX_SIDE) ? MAX_SIDE : source_width;
      h   = (source_height > MAX_SIDE) ? MAX_SIDE : source_height;
      col = source_axis(col_per_x, col_per_y, col_offset, item.dest_x, item.dest_y);
      row = source_axis(row_per_x, row_per_y, row_offset, item.dest_x, item.dest_y);
      px.gray       = '0;
      px.inside_res = 1'b0;
      if (col >= 0 && row >= 0 && col < w && row < h) begin
         px.gray       = gray_store[(row * w + col) % FRAME_PIXELS];
         px.inside_res = 1'b1;
      end
      return px;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         col_per_x     = COEF_ONE;
         col_per_y     = '0;
         row_per_x     = '0;
         row_per_y     = COEF_ONE;
         col_offset    = '0;
         row_offset    = '0;
         source_width  = SIDE_RESET;
         source_height = SIDE_RESET;
         failures      = 0;
         pending_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COL_PER_X:     col_per_x     = csr_data[CPAR_W-1:0];
               CSR_COL_PER_Y:     col_per_y     = csr_data[CPAR_W-1:0];
               CSR_ROW_PER_X:     row_per_x     = csr_data[CPAR_W-1:0];
               CSR_ROW_PER_Y:     row_per_y     = csr_data[CPAR_W-1:0];
               CSR_COL_OFFSET:    col_offset    = csr_data[OFF_W-1:0];
               CSR_ROW_OFFSET:    row_offset    = csr_data[OFF_W-1:0];
               CSR_SOURCE_WIDTH:  source_width  = csr_data[SIDE_FLD_W-1:0];
               CSR_SOURCE_HEIGHT: source_height = csr_data[SIDE_FLD_W-1:0];
               default: ;
            endcase
         end
         // results first: one accepted on this edge cannot belong to a warp taken now
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result gray %0d inside %0b",
                                         rsp_data.gray, rsp_data.inside_res));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_data.gray !== want.gray)
                  report_mismatch($sformatf("gray %0d, wanted %0d", rsp_data.gray, want.gray));
               if (rsp_data.inside_res !== want.inside_res)
                  report_mismatch($sformatf("inside flag %0b, wanted %0b",
                                            rsp_data.inside_res, want.inside_res));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.func == FUNC_LOAD)
               gray_store[req_data.pixel_address] = GRAY_W'((int'(req_data.red)
                  + int'(req_data.green) + int'(req_data.blue)) / 3);
            else
               pending_pixels.push_back(predict_pixel(req_data));
         end
      end
      waiting <= pending_pixels.size();
   end

endmodule

/* tb/sv/affine_warp_nearest_gray_tb.sv */
`timescale 1ns / 100ps
module affine_warp_nearest_gray_tb;
   import afw_pkg::*;

   localparam int FRAME_PIXELS  = FRAME_PIXELS_DEF;
   localparam int MAX_SIDE      = MAX_SIDE_DEF;
   // margin after the drain so that trailing loads still in the pipeline reach the store
   localparam int SETTLE_CYCLES = 16;
   // longest run of edges with no handshake at all before we give up
   localparam int STUCK_LIMIT   = 4000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 38;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_COL_PER_X;
   logic [CSR_DATA_W-1:0] csr_data  = '0;
   int                    failures;
   int                    waiting;

   // stimulus side view of the registers, used to steer warps onto written pixels only
   longint reg_value [8] = '{longint'(COEF_ONE), 0, 0, longint'(COEF_ONE), 0, 0,
                             longint'(SIDE_RESET), longint'(SIDE_RESET)};
   longint plan [8];
   bit     frame_written [FRAME_PIXELS];
   int     span_x, span_y;
   int     idle_pct  = 0;
   int     stall_pct = 0;
   int     quiet_cycles = 0;
   int     loads_sent, warps_sent, inside_sent, settings_used;

   affine_warp_nearest_gray dut (.*);

   affine_warp_nearest_gray_checker chk (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure, independent of what the block offers
   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);

   // watchdog: no item moving on any channel for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STUCK_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results outstanding", STUCK_LIMIT, waiting);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // integer part of a q.16 value, truncated toward zero
   function automatic longint whole_part(input longint s);
      return (s >= 0) ? (s >>> FRAC_W) : -((-s) >>> FRAC_W);
   endfunction

   // store address a warp of (x, y) would read, or -1 when it falls outside
   function automatic int mapped_address(input int x, input int y);
      longint col, row, w, h;
      col = whole_part(reg_value[CSR_COL_PER_X] * x + reg_value[CSR_COL_PER_Y] * y
                       + reg_value[CSR_COL_OFFSET] + HALF_Q16);
      row = whole_part(reg_value[CSR_ROW_PER_X] * x + reg_value[CSR_ROW_PER_Y] * y
                       + reg_value[CSR_ROW_OFFSET] + HALF_Q16);
      w   = (reg_value[CSR_SOURCE_WIDTH] > MAX_SIDE) ? MAX_SIDE : reg_value[CSR_SOURCE_WIDTH];
      h   = (reg_value[CSR_SOURCE_HEIGHT] > MAX_SIDE) ? MAX_SIDE : reg_value[CSR_SOURCE_HEIGHT];
      if (col < 0 || row < 0 || col >= w || row >= h)
         return -1;
      return int'((row * w + col) % FRAME_PIXELS);
   endfunction

   // present one item and hold it until the block takes it; valid only drops for a gap
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_load(input int addr, input int r, input int g, input int b);
      req_type item;
      item.func          = FUNC_LOAD;
      item.pixel_address = PA_W'(addr);
      item.red           = RGB_W'(r);
      item.green         = RGB_W'(g);
      item.blue          = RGB_W'(b);
      // warp fields are don't-care on a load, so fill them with noise
      item.dest_x        = DEST_W'($urandom());
      item.dest_y        = DEST_W'($urandom());
      frame_written[addr] = 1'b1;
      loads_sent++;
      send_item(item);
   endtask

   task automatic send_random_load(input int addr);
      send_load(addr, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // a warp that would land on a never-written pixel gets that pixel loaded first
   task automatic send_warp(input int x, input int y);
      req_type item;
      int      addr;
      addr = mapped_address(x, y);
      if (addr >= 0 && !frame_written[addr])
         send_random_load(addr);
      item.func          = FUNC_WARP;
      item.pixel_address = PA_W'($urandom());
      item.red           = RGB_W'($urandom());
      item.green         = RGB_W'($urandom());
      item.blue          = RGB_W'($urandom());
      item.dest_x        = DEST_W'(x);
      item.dest_y        = DEST_W'(y);
      warps_sent++;
      if (addr >= 0)
         inside_sent++;
      send_item(item);
   endtask

   // stop sending and wait for every outstanding warp result to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
   endtask

   // write all eight registers back to back; loads may still be in flight, so settle first
   task automatic program_warp();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= CSR_DATA_W'(plan[i]);
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         reg_value[i] = plan[i];
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // pick the register set for a phase, plus a destination window that mostly lands inside
   task automatic pick_setting(input int k);
      plan   = '{longint'(COEF_ONE), 0, 0, longint'(COEF_ONE), 0, 0, 256, 256};
      span_x = 299;
      span_y = 299;
      case (k)
         0: ;                                      // plain identity, edges of a 256 square
         1: begin                                  // offsets of -0.7 leave small negative fractions
            plan[CSR_COL_OFFSET]    = -45875;
            plan[CSR_ROW_OFFSET]    = -45875;
            plan[CSR_SOURCE_WIDTH]  = 64;
            plan[CSR_SOURCE_HEIGHT] = 64;
            span_x = 70;
            span_y = 70;
         end
         2: begin                                  // full 1024 square, reads wrap round the store
            plan[CSR_SOURCE_WIDTH]  = 1024;
            plan[CSR_SOURCE_HEIGHT] = 1024;
            span_x = 1023;
            span_y = 1023;
         end
         3: begin                                  // oversized sides saturate, half scale
            plan[CSR_COL_PER_X]     = 32768;
            plan[CSR_ROW_PER_Y]     = 32768;
            plan[CSR_SOURCE_WIDTH]  = 2047;
            plan[CSR_SOURCE_HEIGHT] = 1025;
            span_x = 1023;
            span_y = 1023;
         end
         4: begin                                  // zero width: nothing is ever inside
            plan[CSR_SOURCE_WIDTH]  = 0;
            plan[CSR_SOURCE_HEIGHT] = 100;
            span_x = 1023;
            span_y = 1023;
         end
         5: begin                                  // coefficient and offset extremes
            plan[CSR_COL_PER_X]     = 8388607;
            plan[CSR_COL_PER_Y]     = -8388608;
            plan[CSR_ROW_PER_X]     = -8388608;
            plan[CSR_ROW_PER_Y]     = 8388607;
            plan[CSR_COL_OFFSET]    = 536870911;
            plan[CSR_ROW_OFFSET]    = -536870912;
            plan[CSR_SOURCE_WIDTH]  = 1024;
            plan[CSR_SOURCE_HEIGHT] = 1024;
            span_x = 1023;
            span_y = 1023;
         end
         6: begin                                  // thirty degree rotation with a shift
            plan[CSR_COL_PER_X]     = 56756;
            plan[CSR_COL_PER_Y]     = -32768;
            plan[CSR_ROW_PER_X]     = 32768;
            plan[CSR_ROW_PER_Y]     = 56756;
            plan[CSR_COL_OFFSET]    = 100 * 65536;
            plan[CSR_ROW_OFFSET]    = -20 * 65536;
            plan[CSR_SOURCE_WIDTH]  = 200;
            plan[CSR_SOURCE_HEIGHT] = 150;
            span_x = 255;
            span_y = 255;
         end
         7: begin                                  // single pixel source, quarter scale
            plan[CSR_COL_PER_X]     = 16384;
            plan[CSR_ROW_PER_Y]     = 16384;
            plan[CSR_COL_OFFSET]    = 12345;
            plan[CSR_ROW_OFFSET]    = 12345;
            plan[CSR_SOURCE_WIDTH]  = 1;
            plan[CSR_SOURCE_HEIGHT] = 1;
            span_x = 7;
            span_y = 7;
         end
         default: begin                            // random map within +-2.0, small source
            for (int i = 0; i < 4; i++)
               plan[i] = longint'($urandom_range(0, 262144)) - 131072;
            plan[CSR_COL_OFFSET]    = (longint'($urandom_range(0, 600)) - 300) * 65536
                                      + $urandom_range(0, 65535);
            plan[CSR_ROW_OFFSET]    = (longint'($urandom_range(0, 600)) - 300) * 65536
                                      + $urandom_range(0, 65535);
            plan[CSR_SOURCE_WIDTH]  = $urandom_range(1, 300);
            plan[CSR_SOURCE_HEIGHT] = $urandom_range(1, 300);
            span_x = 255;
            span_y = 255;
         end
      endcase
   endtask

   task automatic run_phase(input int k);
      int addr;
      pick_setting(k);
      program_warp();
      // idling pattern rotates through four mixes of gaps and stalls across the settings
      case (k % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 85; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 85; end
         default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // two opposite corners of the destination window and all corners of the whole destination range
      send_warp(0, 0);
      send_warp(span_x, span_y);
      send_warp(1023, 1023);
      send_warp(0, 1023);
      send_warp(1023, 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // now and then hold off until the pipe is empty, then carry on
         if (k % 3 == 1 && n == PHASE_ITEMS / 2)
            wait_drained();
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 1)) begin
               send_random_load($urandom_range(0, FRAME_PIXELS - 1));
            end else begin
               // fill a pixel that a later warp is likely to want
               addr = mapped_address($urandom_range(0, span_x), $urandom_range(0, span_y));
               send_random_load(addr >= 0 ? addr : $urandom_range(0, FRAME_PIXELS - 1));
            end
         end else if ($urandom_range(0, 9) == 0) begin
            send_warp($urandom_range(0, 1023), $urandom_range(0, 1023));
         end else begin
            send_warp($urandom_range(0, span_x), $urandom_range(0, span_y));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on the reset map: 256 x 256 identity
      send_load(0, 0, 0, 0);
      send_load(FRAME_PIXELS - 1, 255, 255, 255);
      send_load(255, 255, 0, 0);
      send_load(256, 0, 255, 1);
      send_load(16'h5555, 8'hAA, 8'h55, 8'hAA);
      send_load(16'hAAAA, 8'h55, 8'hAA, 8'h55);
      send_load(1, 1, 1, 0);                       // sum below three rounds down to zero
      send_load(2, 254, 255, 255);
      send_warp(0, 0);
      send_warp(1, 0);
      send_warp(2, 0);
      send_warp(255, 0);
      send_warp(0, 1);
      send_warp(255, 255);
      send_warp(85, 85);
      send_warp(170, 170);
      send_warp(3, 3);                             // never loaded, so a load goes ahead of it
      send_warp(256, 0);                           // just past the right edge
      send_warp(0, 256);                           // just past the bottom edge
      send_warp(1023, 1023);
      send_warp(10'h2AA, 10'h155);
      send_warp(10'h155, 10'h2AA);

      for (int k = 0; k < PHASES; k++)
         run_phase(k);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d warps (%0d mapped inside the source)",
               loads_sent, warps_sent, inside_sent);
      $display("over %0d register settings incl. wrap, saturation, zero size and extremes",
               settings_used + 1);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/afw_pkg.sv
hdl/afw_ram.sv
hdl/affine_warp_nearest_gray.sv
hdl/afw_checker.sv
tb/sv/affine_warp_nearest_gray_checker.sv
tb/sv/affine_warp_nearest_gray_tb.sv
